>>> design/vpic_pkg.sv
// Package for the Verlet particle integrate-and-clamp pipeline.
// Holds formats, the register index enum, the pass-through item struct and
// saturation/rounding helpers. No dependencies.
package vpic_pkg;

  localparam int PosW   = 32;
  localparam int GainW  = 17;
  localparam int RadW   = 31;
  localparam int LimW   = 31;
  localparam int RootW  = 32;   // bits of sqrt of a 63-bit sum
  localparam int QuoW   = 31;   // quotient bits, bounded by the travel limit
  localparam int NumSt  = 5 + RootW + 1 + QuoW + 4;

  localparam logic [GainW-1:0] GainOne = 17'd65536;

  typedef logic signed [PosW-1:0] pos_t;

  typedef enum logic [2:0] {
    REG_DAMP, REG_LIMIT, REG_GRAV, REG_BOUNCE,
    REG_BMINX, REG_BMAXX, REG_BMINY, REG_BMAXY
  } reg_e;

  typedef struct packed {
    pos_t              px;
    pos_t              py;
    logic [RadW-1:0]   rad;
    logic              asleep;
    pos_t              dx;
    pos_t              dy;
    logic [LimW-1:0]   ax;
    logic [LimW-1:0]   ay;
    logic              lim;
  } pass_t;

  function automatic pos_t sat_pos(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    else if (v < -36'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  // round to nearest, ties toward +inf, of a product with a Q1.16 gain
  function automatic logic signed [32:0] gain_rnd(input logic signed [49:0] p);
    logic signed [49:0] t;
    t = (p + 50'sd32768) >>> 16;
    return t[32:0];
  endfunction

endpackage

>>> design/verlet_particle_integrate_clamp.sv
// Top level: Verlet step with damping, travel limit (sqrt and divide),
// gravity and box clamp with restitution, as one stall-together pipeline.
// Depends on vpic_pkg.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata: pos_x, pos_y, prev_x, prev_y, radius
//            |           |                        | tuser: asleep
//  m_axis    | out       | tvalid/tready          | tdata: new_pos_x, new_pos_y, new_prev_x,
//            |           |                        |        new_prev_y
//  cfg       | in        | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not held; the depth is set by the 32 bit-per-stage square
// root and the 31 bit-per-stage restoring dividers of the travel limit.
// Reset clears valid bits and config registers, but sets damping to one; payload is not reset.
// A held output stalls every stage together; nothing is dropped or repeated.
// Config registers are always ready.
module verlet_particle_integrate_clamp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [159:0]  s_axis_tdata,   // pos_x, pos_y, prev_x, prev_y, radius, pad
  input  logic          s_axis_tuser,   // asleep
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [127:0]  m_axis_tdata,   // new_pos_x, new_pos_y, new_prev_x, new_prev_y
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int NSt = vpic_pkg::NumSt;
  localparam int RW  = vpic_pkg::RootW;
  localparam int QW  = vpic_pkg::QuoW;

  // configuration
  logic [16:0]        damp_q, bounce_q;
  logic [30:0]        lim_q;
  vpic_pkg::pos_t     grav_q, bminx_q, bmaxx_q, bminy_q, bmaxy_q;
  logic [61:0]        llim_q;
  logic [16:0]        gain_w;

  assign cfg_ready_o = 1'b1;
  assign gain_w = (cfg_data_i[16:0] > vpic_pkg::GainOne) ? vpic_pkg::GainOne
                                                         : cfg_data_i[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_q   <= vpic_pkg::GainOne;
      lim_q    <= '0;
      grav_q   <= '0;
      bounce_q <= '0;
      bminx_q  <= '0;
      bmaxx_q  <= '0;
      bminy_q  <= '0;
      bmaxy_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (vpic_pkg::reg_e'(cfg_index_i))
        vpic_pkg::REG_DAMP:   damp_q   <= gain_w;
        vpic_pkg::REG_LIMIT:  lim_q    <= cfg_data_i[30:0];
        vpic_pkg::REG_GRAV:   grav_q   <= cfg_data_i;
        vpic_pkg::REG_BOUNCE: bounce_q <= gain_w;
        vpic_pkg::REG_BMINX:  bminx_q  <= cfg_data_i;
        vpic_pkg::REG_BMAXX:  bmaxx_q  <= cfg_data_i;
        vpic_pkg::REG_BMINY:  bminy_q  <= cfg_data_i;
        vpic_pkg::REG_BMAXY:  bmaxy_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    llim_q <= 62'(lim_q) * 62'(lim_q);
  end

  // pipeline control
  logic           en;
  logic [NSt-1:0] vld_q;

  assign en            = !vld_q[NSt-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSt-2:0], s_axis_tvalid};
    end
  end

  // front: capture, damp, magnitudes, squares, limit test
  vpic_pkg::pass_t    f0_it_q, f1_it_q, f2_it_q, f3_it_q, f4_it_q;
  vpic_pkg::pos_t     f0_qx_q, f0_qy_q;
  logic signed [49:0] f1_prx_q, f1_pry_q;
  logic               f2_k_q, f3_k_q;
  logic [61:0]        f3_sx_q, f3_sy_q;
  logic [62:0]        f4_s_q;

  vpic_pkg::pass_t    f0_it_d, f2_it_d, f4_it_d;
  vpic_pkg::pos_t     rx_w, ry_w;
  logic [32:0]        gx_w, gy_w;
  logic [31:0]        mx_w, my_w;
  logic               k_w;
  logic [62:0]        s_w;

  always_comb begin
    f0_it_d        = '0;
    f0_it_d.px     = s_axis_tdata[31:0];
    f0_it_d.py     = s_axis_tdata[63:32];
    f0_it_d.rad    = s_axis_tdata[158:128];
    f0_it_d.asleep = s_axis_tuser;

    rx_w = vpic_pkg::sat_pos(36'(f0_it_q.px) - 36'(f0_qx_q));
    ry_w = vpic_pkg::sat_pos(36'(f0_it_q.py) - 36'(f0_qy_q));

    gx_w = vpic_pkg::gain_rnd(f1_prx_q);
    gy_w = vpic_pkg::gain_rnd(f1_pry_q);
    f2_it_d    = f1_it_q;
    f2_it_d.dx = gx_w[31:0];
    f2_it_d.dy = gy_w[31:0];
    mx_w = gx_w[31] ? 32'(-gx_w) : gx_w[31:0];
    my_w = gy_w[31] ? 32'(-gy_w) : gy_w[31:0];
    // bring both magnitudes below 2^31
    k_w  = mx_w[31] | my_w[31];
    f2_it_d.ax = k_w ? mx_w[31:1] : mx_w[30:0];
    f2_it_d.ay = k_w ? my_w[31:1] : my_w[30:0];

    s_w = 63'(f3_sx_q) + 63'(f3_sy_q);
    f4_it_d     = f3_it_q;
    f4_it_d.lim = !f3_it_q.asleep && (lim_q != '0) && (f3_k_q || (s_w > 63'(llim_q)));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f0_it_q  <= f0_it_d;
      f0_qx_q  <= s_axis_tdata[95:64];
      f0_qy_q  <= s_axis_tdata[127:96];
      f1_it_q  <= f0_it_q;
      f1_prx_q <= 50'(rx_w) * 50'($signed({1'b0, damp_q}));
      f1_pry_q <= 50'(ry_w) * 50'($signed({1'b0, damp_q}));
      f2_it_q  <= f2_it_d;
      f2_k_q   <= k_w;
      f3_it_q  <= f2_it_q;
      f3_k_q   <= f2_k_q;
      f3_sx_q  <= 62'(f2_it_q.ax) * 62'(f2_it_q.ax);
      f3_sy_q  <= 62'(f2_it_q.ay) * 62'(f2_it_q.ay);
      f4_it_q  <= f4_it_d;
      f4_s_q   <= s_w;
    end
  end

  // square root, one result bit per stage
  vpic_pkg::pass_t sq_it_q   [RW];
  logic [63:0]     sq_rem_q  [RW];
  logic [RW-1:0]   sq_root_q [RW];

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int B = RW - 1 - j;
    vpic_pkg::pass_t it_in;
    logic [63:0]     rem_in, cand;
    logic [RW-1:0]   root_in;

    if (j == 0) begin : g_first
      assign it_in   = f4_it_q;
      assign rem_in  = 64'(f4_s_q);
      assign root_in = '0;
    end else begin : g_next
      assign it_in   = sq_it_q[j-1];
      assign rem_in  = sq_rem_q[j-1];
      assign root_in = sq_root_q[j-1];
    end

    assign cand = (64'(root_in) << (B + 1)) | (64'd1 << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_it_q[j] <= it_in;
        if (rem_in >= cand) begin
          sq_rem_q[j]  <= rem_in - cand;
          sq_root_q[j] <= root_in | (RW'(1) << B);
        end else begin
          sq_rem_q[j]  <= rem_in;
          sq_root_q[j] <= root_in;
        end
      end
    end
  end

  // scale magnitudes by the limit
  vpic_pkg::pass_t mu_it_q, mu_it_d;
  logic [61:0]     mu_nx_q, mu_ny_q;
  logic [RW-1:0]   mu_r_q;

  // drop the limit when the root is zero
  always_comb begin
    mu_it_d     = sq_it_q[RW-1];
    mu_it_d.lim = sq_it_q[RW-1].lim && (sq_root_q[RW-1] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mu_it_q     <= mu_it_d;
      mu_nx_q     <= 62'(sq_it_q[RW-1].ax) * 62'(lim_q);
      mu_ny_q     <= 62'(sq_it_q[RW-1].ay) * 62'(lim_q);
      mu_r_q      <= sq_root_q[RW-1];
    end
  end

  // two restoring dividers, one quotient bit per stage
  vpic_pkg::pass_t dv_it_q [QW];
  logic [61:0]     dv_rx_q [QW];
  logic [61:0]     dv_ry_q [QW];
  logic [QW-1:0]   dv_qx_q [QW];
  logic [QW-1:0]   dv_qy_q [QW];
  logic [RW-1:0]   dv_r_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    vpic_pkg::pass_t it_in;
    logic [61:0]     rx_in, ry_in;
    logic [QW-1:0]   qx_in, qy_in;
    logic [RW-1:0]   r_in;
    logic [62:0]     dsh;

    if (j == 0) begin : g_first
      assign it_in = mu_it_q;
      assign rx_in = mu_nx_q;
      assign ry_in = mu_ny_q;
      assign qx_in = '0;
      assign qy_in = '0;
      assign r_in  = mu_r_q;
    end else begin : g_next
      assign it_in = dv_it_q[j-1];
      assign rx_in = dv_rx_q[j-1];
      assign ry_in = dv_ry_q[j-1];
      assign qx_in = dv_qx_q[j-1];
      assign qy_in = dv_qy_q[j-1];
      assign r_in  = dv_r_q[j-1];
    end

    assign dsh = 63'(r_in) << B;

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_it_q[j] <= it_in;
        dv_r_q[j]  <= r_in;
        if (63'(rx_in) >= dsh) begin
          dv_rx_q[j] <= 62'(63'(rx_in) - dsh);
          dv_qx_q[j] <= qx_in | (QW'(1) << B);
        end else begin
          dv_rx_q[j] <= rx_in;
          dv_qx_q[j] <= qx_in;
        end
        if (63'(ry_in) >= dsh) begin
          dv_ry_q[j] <= 62'(63'(ry_in) - dsh);
          dv_qy_q[j] <= qy_in | (QW'(1) << B);
        end else begin
          dv_ry_q[j] <= ry_in;
          dv_qy_q[j] <= qy_in;
        end
      end
    end
  end

  // back: integrate, clamp, bounce
  vpic_pkg::pass_t    lt;
  vpic_pkg::pos_t     dxf_w, dyf_w, qxs_w, qys_w;
  vpic_pkg::pos_t     b0_px_q, b0_py_q, b0_qx_q, b0_qy_q;
  logic [30:0]        b0_rad_q;
  vpic_pkg::pos_t     b0_px_d, b0_py_d;

  assign lt    = dv_it_q[QW-1];
  assign qxs_w = $signed({1'b0, dv_qx_q[QW-1]});
  assign qys_w = $signed({1'b0, dv_qy_q[QW-1]});

  always_comb begin
    dxf_w = lt.lim ? (lt.dx[31] ? -qxs_w : qxs_w) : lt.dx;
    dyf_w = lt.lim ? (lt.dy[31] ? -qys_w : qys_w) : lt.dy;
    if (lt.asleep) begin
      b0_px_d = lt.px;
      b0_py_d = lt.py;
    end else begin
      b0_px_d = vpic_pkg::sat_pos(36'(lt.px) + 36'(dxf_w));
      b0_py_d = vpic_pkg::sat_pos(36'(lt.py) + 36'(dyf_w) + 36'(grav_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_px_q  <= b0_px_d;
      b0_py_q  <= b0_py_d;
      b0_qx_q  <= lt.px;
      b0_qy_q  <= lt.py;
      b0_rad_q <= lt.rad;
    end
  end

  logic signed [33:0] rad_w, lox_w, hix_w, loy_w, hiy_w;
  logic signed [32:0] ddx_w, ddy_w;
  vpic_pkg::pos_t     b1_px_d, b1_py_d;
  logic               b1_rfx_d, b1_rfy_d;

  vpic_pkg::pos_t     b1_px_q, b1_py_q, b1_dsx_q, b1_dsy_q;
  logic signed [32:0] b1_dx_q, b1_dy_q;
  logic               b1_rfx_q, b1_rfy_q;

  always_comb begin
    rad_w = $signed({3'b000, b0_rad_q});
    lox_w = 34'(bminx_q) + rad_w;
    hix_w = 34'(bmaxx_q) - rad_w;
    loy_w = 34'(bminy_q) + rad_w;
    hiy_w = 34'(bmaxy_q) - rad_w;
    ddx_w = 33'(b0_px_q) - 33'(b0_qx_q);
    ddy_w = 33'(b0_py_q) - 33'(b0_qy_q);

    b1_px_d  = b0_px_q;
    b1_rfx_d = 1'b0;
    if (34'(b0_px_q) < lox_w) begin
      b1_px_d  = vpic_pkg::sat_pos(36'(lox_w));
      b1_rfx_d = ddx_w < 0;
    end else if (34'(b0_px_q) > hix_w) begin
      b1_px_d  = vpic_pkg::sat_pos(36'(hix_w));
      b1_rfx_d = ddx_w > 0;
    end

    b1_py_d  = b0_py_q;
    b1_rfy_d = 1'b0;
    if (34'(b0_py_q) < loy_w) begin
      b1_py_d  = vpic_pkg::sat_pos(36'(loy_w));
      b1_rfy_d = ddy_w < 0;
    end else if (34'(b0_py_q) > hiy_w) begin
      b1_py_d  = vpic_pkg::sat_pos(36'(hiy_w));
      b1_rfy_d = ddy_w > 0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_px_q  <= b1_px_d;
      b1_py_q  <= b1_py_d;
      b1_dx_q  <= ddx_w;
      b1_dy_q  <= ddy_w;
      b1_dsx_q <= vpic_pkg::sat_pos(36'(ddx_w));
      b1_dsy_q <= vpic_pkg::sat_pos(36'(ddy_w));
      b1_rfx_q <= b1_rfx_d;
      b1_rfy_q <= b1_rfy_d;
    end
  end

  vpic_pkg::pos_t     b2_px_q, b2_py_q;
  logic signed [32:0] b2_dx_q, b2_dy_q;
  logic signed [49:0] b2_prx_q, b2_pry_q;
  logic               b2_rfx_q, b2_rfy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_px_q  <= b1_px_q;
      b2_py_q  <= b1_py_q;
      b2_dx_q  <= b1_dx_q;
      b2_dy_q  <= b1_dy_q;
      b2_rfx_q <= b1_rfx_q;
      b2_rfy_q <= b1_rfy_q;
      b2_prx_q <= 50'(b1_dsx_q) * 50'($signed({1'b0, bounce_q}));
      b2_pry_q <= 50'(b1_dsy_q) * 50'($signed({1'b0, bounce_q}));
    end
  end

  logic signed [33:0] dnx_w, dny_w;
  vpic_pkg::pos_t     out_px_q, out_py_q, out_qx_q, out_qy_q;

  // reflected displacement is the negated rounded bounce product
  assign dnx_w = b2_rfx_q ? -34'(vpic_pkg::gain_rnd(b2_prx_q)) : 34'(b2_dx_q);
  assign dny_w = b2_rfy_q ? -34'(vpic_pkg::gain_rnd(b2_pry_q)) : 34'(b2_dy_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_px_q <= b2_px_q;
      out_py_q <= b2_py_q;
      out_qx_q <= vpic_pkg::sat_pos(36'(b2_px_q) - 36'(dnx_w));
      out_qy_q <= vpic_pkg::sat_pos(36'(b2_py_q) - 36'(dny_w));
    end
  end

  assign m_axis_tdata = {out_qy_q, out_qx_q, out_py_q, out_px_q};

endmodule
